// ===== rtl/rrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the ready/sleep task scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int TASK_W  = 4;
  localparam int MODE_W  = 3;
  localparam int TICKS_W = 32;
  localparam int WOKEN_W = 5;

  localparam logic [MODE_W-1:0] MODE_READY_ENQ = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLEEP_ENQ = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SWITCH    = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_READY_ENQ,
    OP_REMOVE,
    OP_SLEEP_ENQ,
    OP_TICK,
    OP_SWITCH
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_DEC,
    S_TICK_WAKE,
    S_SW_POP,
    S_DONE
  } eng_state_e;

  // Raw item as it arrives.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TASK_W-1:0]  task_id;
    logic [TICKS_W-1:0] sleep_ticks;
    logic               current_running;
    logic               current_overflow;
  } item_t;

  // Classified operation handed to the engine.
  typedef struct packed {
    op_e                op;
    logic [TASK_W-1:0]  task_id;
    logic [TICKS_W-1:0] sleep_ticks;
    logic               running;
    logic               overflow;
    logic               task_ok;
  } op_t;

  typedef struct packed {
    logic [TASK_W-1:0]  chosen_task;
    logic               chose_idle;
    logic               accepted;
    logic [WOKEN_W-1:0] woken_count;
    logic               current_suspended;
  } res_t;

endpackage

// ===== rtl/rrs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_front
// Two-entry input queue that classifies the oldest item for the engine.
// ----------------------------------------------------------------------------
module rrs_front import rrs_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  item_t item_i,
  output logic  op_valid_o,
  input  logic  op_pop_i,
  output op_t   op_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        wr_en, rd_en;
  item_t       head;

  assign full_o     = (cnt_q == 2'd2);
  assign op_valid_o = (cnt_q != 2'd0);
  assign wr_en      = push_i && !full_o;
  assign rd_en      = op_pop_i && op_valid_o;
  assign head       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= item_i;
  end

  // Classification of the oldest item.
  always_comb begin
    op_o.task_id     = head.task_id;
    op_o.sleep_ticks = head.sleep_ticks;
    op_o.running     = head.current_running;
    op_o.overflow    = head.current_overflow;
    op_o.task_ok     = (int'(head.task_id) < MAX_TASKS);
    case (head.mode)
      MODE_READY_ENQ: op_o.op = OP_READY_ENQ;
      MODE_REMOVE:    op_o.op = OP_REMOVE;
      MODE_SLEEP_ENQ: op_o.op = OP_SLEEP_ENQ;
      MODE_TICK:      op_o.op = OP_TICK;
      MODE_SWITCH:    op_o.op = OP_SWITCH;
      default:        op_o.op = OP_NOP;
    endcase
  end

endmodule

// ===== rtl/rrs_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_engine
// Holds the ready and sleep queues and carries out one operation at a time.
// ----------------------------------------------------------------------------
module rrs_engine import rrs_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic op_valid_i,
  output logic op_pop_o,
  input  op_t  op_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int CW = $clog2(MAX_TASKS + 1);

  eng_state_e state_q, state_d;

  logic [TASK_W-1:0]  rdy_q [MAX_TASKS];
  logic [TASK_W-1:0]  rdy_d [MAX_TASKS];
  logic [TASK_W-1:0]  slp_q [MAX_TASKS];
  logic [TASK_W-1:0]  slp_d [MAX_TASKS];
  logic [TICKS_W-1:0] rem_q [MAX_TASKS];
  logic [TICKS_W-1:0] rem_d [MAX_TASKS];
  logic [CW-1:0]      rdy_cnt_q, rdy_cnt_d, slp_cnt_q, slp_cnt_d;
  logic [MAX_TASKS-1:0] in_rdy_q, in_rdy_d, in_slp_q, in_slp_d;
  logic [TASK_W-1:0]  cur_task_q, cur_task_d;
  logic               cur_idle_q, cur_idle_d, cur_valid_q, cur_valid_d;
  res_t               res_q, res_d;

  logic [TASK_W-1:0]    look_task;
  logic [MAX_TASKS-1:0] look_hot, wake_hot, head_hot, rdy_tail;
  logic [MAX_TASKS-1:0] rdy_after, slp_after, slp_le;
  logic                 look_rdy, look_slp, acc_r, acc_s;
  logic                 requeue;

  // Lookups shared by the operations.
  always_comb begin
    look_task = (op_i.op == OP_SWITCH) ? cur_task_q : op_i.task_id;
    acc_r = 1'b0;
    acc_s = 1'b0;
    for (int j = 0; j < MAX_TASKS; j++) begin
      look_hot[j] = (int'(look_task) == j);
      wake_hot[j] = (int'(slp_q[0]) == j);
      head_hot[j] = (int'(rdy_q[0]) == j);
      rdy_tail[j] = (CW'(j) == rdy_cnt_q);
      acc_r = acc_r || ((CW'(j) < rdy_cnt_q) && (rdy_q[j] == op_i.task_id));
      acc_s = acc_s || ((CW'(j) < slp_cnt_q) && (slp_q[j] == op_i.task_id));
      rdy_after[j] = acc_r;
      slp_after[j] = acc_s;
      slp_le[j]    = (CW'(j) < slp_cnt_q) && (rem_q[j] <= op_i.sleep_ticks);
    end
    look_rdy = |(in_rdy_q & look_hot);
    look_slp = |(in_slp_q & look_hot);
    requeue  = cur_valid_q && !op_i.overflow && op_i.running && !cur_idle_q
               && !look_rdy && !look_slp;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          case (op_i.op)
            OP_TICK:   state_d = S_TICK_DEC;
            OP_SWITCH: state_d = S_SW_POP;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_TICK_DEC:  state_d = S_TICK_WAKE;
      S_TICK_WAKE: begin
        if (slp_cnt_q == '0 || rem_q[0] != '0) state_d = S_DONE;
      end
      S_SW_POP: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    rdy_d = rdy_q;  slp_d = slp_q;  rem_d = rem_q;
    rdy_cnt_d = rdy_cnt_q;  slp_cnt_d = slp_cnt_q;
    in_rdy_d = in_rdy_q;  in_slp_d = in_slp_q;
    cur_task_d = cur_task_q;  cur_idle_d = cur_idle_q;  cur_valid_d = cur_valid_q;
    res_d = res_q;
    op_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          res_d = '0;
          case (op_i.op)
            OP_READY_ENQ: begin
              if (op_i.task_ok && !look_rdy && !look_slp) begin
                for (int j = 0; j < MAX_TASKS; j++)
                  if (rdy_tail[j]) rdy_d[j] = op_i.task_id;
                rdy_cnt_d = rdy_cnt_q + 1'b1;
                in_rdy_d = in_rdy_q | look_hot;
                res_d.accepted = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (op_i.task_ok && look_rdy) begin
                for (int j = 0; j < MAX_TASKS - 1; j++)
                  if (rdy_after[j]) rdy_d[j] = rdy_q[j+1];
                rdy_cnt_d = rdy_cnt_q - 1'b1;
                in_rdy_d = in_rdy_q & ~look_hot;
                res_d.accepted = 1'b1;
              end else if (op_i.task_ok && look_slp) begin
                for (int j = 0; j < MAX_TASKS - 1; j++) begin
                  if (slp_after[j]) begin
                    slp_d[j] = slp_q[j+1];
                    rem_d[j] = rem_q[j+1];
                  end
                end
                slp_cnt_d = slp_cnt_q - 1'b1;
                in_slp_d = in_slp_q & ~look_hot;
                res_d.accepted = 1'b1;
              end
            end
            OP_SLEEP_ENQ: begin
              if (op_i.task_ok && !look_rdy && !look_slp) begin
                // Entries above the new count move up one place.
                if (!slp_le[0]) begin
                  slp_d[0] = op_i.task_id;
                  rem_d[0] = op_i.sleep_ticks;
                end
                for (int j = 1; j < MAX_TASKS; j++) begin
                  if (!slp_le[j]) begin
                    if (slp_le[j-1]) begin
                      slp_d[j] = op_i.task_id;
                      rem_d[j] = op_i.sleep_ticks;
                    end else begin
                      slp_d[j] = slp_q[j-1];
                      rem_d[j] = rem_q[j-1];
                    end
                  end
                end
                slp_cnt_d = slp_cnt_q + 1'b1;
                in_slp_d = in_slp_q | look_hot;
                res_d.accepted = 1'b1;
              end
            end
            OP_SWITCH: begin
              if (cur_valid_q && op_i.overflow) res_d.current_suspended = 1'b1;
              if (requeue) begin
                for (int j = 0; j < MAX_TASKS; j++)
                  if (rdy_tail[j]) rdy_d[j] = cur_task_q;
                rdy_cnt_d = rdy_cnt_q + 1'b1;
                in_rdy_d = in_rdy_q | look_hot;
              end
            end
            default: ;
          endcase
        end
      end
      S_TICK_DEC: begin
        for (int j = 0; j < MAX_TASKS; j++)
          if ((CW'(j) < slp_cnt_q) && (rem_q[j] != '0)) rem_d[j] = rem_q[j] - 1'b1;
      end
      S_TICK_WAKE: begin
        // Expired entries sit at the head of the sorted list.
        if (slp_cnt_q != '0 && rem_q[0] == '0) begin
          for (int j = 0; j < MAX_TASKS; j++)
            if (rdy_tail[j]) rdy_d[j] = slp_q[0];
          rdy_cnt_d = rdy_cnt_q + 1'b1;
          for (int j = 0; j < MAX_TASKS - 1; j++) begin
            slp_d[j] = slp_q[j+1];
            rem_d[j] = rem_q[j+1];
          end
          slp_cnt_d = slp_cnt_q - 1'b1;
          in_slp_d = in_slp_q & ~wake_hot;
          in_rdy_d = in_rdy_q | wake_hot;
          res_d.woken_count = res_q.woken_count + 1'b1;
        end
      end
      S_SW_POP: begin
        cur_valid_d = 1'b1;
        if (rdy_cnt_q == '0) begin
          res_d.chose_idle = 1'b1;
          cur_idle_d = 1'b1;
          cur_task_d = '0;
        end else begin
          for (int j = 0; j < MAX_TASKS - 1; j++) rdy_d[j] = rdy_q[j+1];
          rdy_cnt_d = rdy_cnt_q - 1'b1;
          in_rdy_d = in_rdy_q & ~head_hot;
          res_d.chosen_task = rdy_q[0];
          cur_task_d = rdy_q[0];
          cur_idle_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rdy_cnt_q   <= '0;
      slp_cnt_q   <= '0;
      in_rdy_q    <= '0;
      in_slp_q    <= '0;
      cur_task_q  <= '0;
      cur_idle_q  <= 1'b0;
      cur_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rdy_cnt_q   <= rdy_cnt_d;
      slp_cnt_q   <= slp_cnt_d;
      in_rdy_q    <= in_rdy_d;
      in_slp_q    <= in_slp_d;
      cur_task_q  <= cur_task_d;
      cur_idle_q  <= cur_idle_d;
      cur_valid_q <= cur_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdy_q <= rdy_d;
    slp_q <= slp_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

endmodule

// ===== rtl/rrs_resq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_resq
// Two-entry result queue in front of the result ports.
// ----------------------------------------------------------------------------
module rrs_resq import rrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  output logic res_ready_o,
  input  res_t res_i,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign res_ready_o = (cnt_q != 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign wr_en       = res_valid_i && res_ready_o;
  assign rd_en       = pop_i && !empty_o;
  assign res_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= res_i;
  end

endmodule

// ===== rtl/rtos_ready_sleep_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtos_ready_sleep_task_scheduler
// Task scheduler with a FIFO ready queue and a sorted sleep queue.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Item
// input    | push / full          | mode, task_id, sleep_ticks, current_*
// result   | empty / pop          | chosen_task, chose_idle, accepted, ...
//
// Every item is queued, classified and then executed by the engine, one at a
// time. Enqueue, remove and no-op items go from idle straight to done; a
// switch passes a pop state; a tick passes a decrement state and then a wake
// state that moves expired sleepers to the ready tail one per cycle.
// Reset empties both queues and clears the current task; no clearing pass.
// A full result queue stalls the engine, but two more items may still queue.
// ----------------------------------------------------------------------------
module rtos_ready_sleep_task_scheduler import rrs_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [TASK_W-1:0]  task_id_i,
  input  logic [TICKS_W-1:0] sleep_ticks_i,
  input  logic               current_running_i,
  input  logic               current_overflow_i,
  output logic               empty,
  input  logic               pop,
  output logic [TASK_W-1:0]  chosen_task_o,
  output logic               chose_idle_o,
  output logic               accepted_o,
  output logic [WOKEN_W-1:0] woken_count_o,
  output logic               current_suspended_o
);

  item_t item;
  op_t   op;
  res_t  eng_res, out_res;
  logic  op_valid, op_pop, res_valid, res_ready;

  assign item.mode             = mode_i;
  assign item.task_id          = task_id_i;
  assign item.sleep_ticks      = sleep_ticks_i;
  assign item.current_running  = current_running_i;
  assign item.current_overflow = current_overflow_i;

  // Front: accepts and classifies items.
  rrs_front #(.MAX_TASKS(MAX_TASKS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .item_i     (item),
    .op_valid_o (op_valid),
    .op_pop_i   (op_pop),
    .op_o       (op)
  );

  // Back: owns the queues and the current task.
  rrs_engine #(.MAX_TASKS(MAX_TASKS)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_pop_o    (op_pop),
    .op_i        (op),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (eng_res)
  );

  // Results wait here until popped.
  rrs_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (eng_res),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (out_res)
  );

  assign chosen_task_o       = out_res.chosen_task;
  assign chose_idle_o        = out_res.chose_idle;
  assign accepted_o          = out_res.accepted;
  assign woken_count_o       = out_res.woken_count;
  assign current_suspended_o = out_res.current_suspended;

endmodule

// ===== rtl/rrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrs_checker import rrs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [TASK_W-1:0]  chosen_task_o,
  input logic               chose_idle_o,
  input logic               accepted_o,
  input logic [WOKEN_W-1:0] woken_count_o,
  input logic               current_suspended_o
);

  // An idle pick never names a task.
  a_idle_no_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && chose_idle_o) |-> (chosen_task_o == '0))
    else $error("idle result carries a task number");

  // Switch results never report enqueue or tick fields.
  a_switch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (chose_idle_o || current_suspended_o))
      |-> (!accepted_o && woken_count_o == '0))
    else $error("switch result mixed with other fields");

  // A tick result never carries an accepted flag.
  a_tick_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && woken_count_o != '0) |-> (!accepted_o && chosen_task_o == '0))
    else $error("tick result mixed with other fields");

  // A waiting result's woken count and accepted flag stay until popped.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(woken_count_o) && $stable(accepted_o)))
    else $error("waiting result changed");

endmodule

bind rtos_ready_sleep_task_scheduler rrs_checker u_rrs_checker (.*);
